// File: rtl/rbfe_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the ring buffer frame extractor.
package rbfe_pkg;

	localparam int RING_DEPTH_DEF  = 64;
	localparam int FRAME_BYTES_DEF = 4;
	localparam int MAX_FRAME_BYTES = 4;
	localparam int QUEUE_DEPTH     = 4;

	localparam logic [7:0]  CONSUMED_MARK = 8'hFF;
	localparam logic [8:0]  HEADER_BASE   = 9'd250;
	localparam logic [15:0] TALLY_MAX     = 16'd65500;
	localparam logic [2:0]  HEADER_ID_RESET = 3'd0;
	localparam logic [5:0]  BACKOFF_RESET   = 6'd10;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 8;
	localparam logic [CFG_INDEX_W-1:0] REG_HEADER_ID      = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_RESYNC_BACKOFF = 1'b1;

	localparam logic OP_STORE = 1'b0;
	localparam logic OP_POLL  = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  frame_byte_0;
		logic [7:0]  frame_byte_1;
		logic [7:0]  frame_byte_2;
		logic [7:0]  frame_byte_3;
		logic        new_frame;
		logic [15:0] stall_count;
		logic [15:0] overrun_count;
	} out_item_t;

	// Classified command handed from the front queue to the back sequencer.
	typedef struct packed {
		logic       poll;
		logic [7:0] data;
	} cmd_t;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v >= TALLY_MAX) ? TALLY_MAX : v + 16'd1;
	endfunction

endpackage

// File: rtl/ring_buffer_frame_extractor.sv
`timescale 1ns / 1ps
// Path: a store item passes through the queue, then the back end writes it into the ring.
// A poll steps through the check, scan and copy states, scanning ring bytes (header and frame
// bytes included), then waits in the done state until the result register is free.
// Throughput: one store per cycle while the back end is idle; a poll holds the back end through
// its scan and longer while the previous result waits; the queue keeps accepting while not full.
// Reset: asynchronous; the ring reads as zero through per-entry valid bits, no clearing pass.
module ring_buffer_frame_extractor
	import rbfe_pkg::*;
#(
	parameter int RING_DEPTH  = RING_DEPTH_DEF,
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  in_item_t               in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output out_item_t              out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [2:0] header_id_q;
	logic [5:0] backoff_q;
	logic       cmd_valid;
	logic       cmd_ready;
	cmd_t       cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_id_q <= HEADER_ID_RESET;
			backoff_q   <= BACKOFF_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_HEADER_ID: begin
					header_id_q <= cfg_data[2:0];
				end
				REG_RESYNC_BACKOFF: begin
					backoff_q <= cfg_data[5:0];
				end
				default: begin
				end
			endcase
		end
	end

	rbfe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	rbfe_back #(
		.RING_DEPTH  (RING_DEPTH),
		.FRAME_BYTES (FRAME_BYTES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_ready      (cmd_ready),
		.cmd            (cmd),
		.header_id      (header_id_q),
		.resync_backoff (backoff_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data)
	);

endmodule

// File: rtl/rbfe_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module rbfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/rbfe_front.sv
`timescale 1ns / 1ps
// Front end: accepts input items, classifies them and queues them for the back end.
module rbfe_front
	import rbfe_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	output logic     cmd_valid,
	input  logic     cmd_ready,
	output cmd_t     cmd
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          queue_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;
	cmd_t          cmd_in;

	assign in_ready  = (count_q != CW'(QUEUE_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = queue_q[rd_ptr_q];

	always_comb begin
		cmd_in.poll = (in_data.op == OP_POLL);
		cmd_in.data = in_data.rx_byte;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not grow on push");

	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count did not shrink on pop");

endmodule

// File: rtl/rbfe_back.sv
`timescale 1ns / 1ps
// Back end: ring storage, poll sequencer, counters and the result register.
module rbfe_back
	import rbfe_pkg::*;
#(
	parameter int RING_DEPTH  = RING_DEPTH_DEF,
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_t      cmd,
	input  logic [2:0] header_id,
	input  logic [5:0] resync_backoff,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int IW          = $clog2(RING_DEPTH);
	localparam int GUARD_LIMIT = 4 * RING_DEPTH + 8;
	localparam int GW          = $clog2(GUARD_LIMIT + 1);
	localparam int FBW         = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
	localparam logic [IW-1:0]  LAST_IDX = IW'(RING_DEPTH - 1);
	localparam logic [IW-1:0]  HALF     = IW'(RING_DEPTH / 2);
	localparam logic [FBW-1:0] K_LAST   = FBW'(FRAME_BYTES - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_COPY,
		S_DONE
	} state_t;

	state_t                             state_q;
	state_t                             state_d;
	logic [IW-1:0]                      wr_idx_q;
	logic [IW-1:0]                      prev_wr_q;
	logic [IW-1:0]                      rd_q;
	logic [IW-1:0]                      cur_q;
	logic [15:0]                        stall_q;
	logic [15:0]                        overrun_q;
	logic [MAX_FRAME_BYTES-1:0][7:0]    frame_q;
	logic                               got_q;
	logic [FBW-1:0]                     k_q;
	logic [GW-1:0]                      guard_q;
	logic [RING_DEPTH-1:0]              valid_q;
	logic                               rvalid_q;
	logic                               out_valid_q;
	out_item_t                          out_data_q;

	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic          ram_re;
	logic [IW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	logic [5:0]    backoff_mod;
	logic [4:0]    margin;
	logic [7:0]    data_eff;
	logic          consumed;
	logic          hit;
	logic          wr_ne_rd;
	logic [IW-1:0] restart_pos;
	logic [IW-1:0] start_pos;
	logic [IW-1:0] pos_gap;
	logic          beyond_margin;
	logic          near_end;
	logic [GW-1:0] guard_inc;
	logic          out_free;

	function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] p);
		return (p == LAST_IDX) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [IW-1:0] ring_gap(input logic [IW-1:0] w, input logic [IW-1:0] r);
		logic [IW:0] s;
		s = {1'b0, w} + (IW+1)'(RING_DEPTH) - {1'b0, r};
		if (s >= (IW+1)'(RING_DEPTH)) begin
			s = s - (IW+1)'(RING_DEPTH);
		end
		return s[IW-1:0];
	endfunction

	rbfe_ram #(
		.WIDTH (8),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Reduce the backoff into the ring; at most seven subtractions for the smallest ring.
	always_comb begin
		backoff_mod = resync_backoff;
		for (int i = 0; i < 8; i++) begin
			if ({3'b0, backoff_mod} >= 9'(RING_DEPTH)) begin
				backoff_mod = backoff_mod - 6'(RING_DEPTH);
			end
		end
	end

	assign margin        = resync_backoff[5:1];
	assign data_eff      = rvalid_q ? ram_rdata : 8'h00;
	assign consumed      = (data_eff == CONSUMED_MARK);
	assign hit           = ({1'b0, data_eff} == HEADER_BASE + {6'b0, header_id});
	assign wr_ne_rd      = (wr_idx_q != rd_q);
	assign restart_pos   = ring_gap(wr_idx_q, IW'(backoff_mod));
	assign start_pos     = consumed ? rd_q : restart_pos;
	assign pos_gap       = ring_gap(wr_idx_q, (state_q == S_CHECK) ? start_pos : cur_q);
	assign beyond_margin = (9'(pos_gap) > 9'(margin));
	assign near_end      = (pos_gap < HALF);
	assign guard_inc     = guard_q + 1'b1;
	assign out_free      = !out_valid_q || out_ready;
	assign cmd_ready     = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign out_data      = out_data_q;

	always_comb begin
		state_d   = state_q;
		ram_re    = 1'b0;
		ram_raddr = ring_next(cur_q);
		ram_we    = 1'b0;
		ram_waddr = cur_q;
		ram_wdata = CONSUMED_MARK;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					if (cmd.poll) begin
						ram_re    = 1'b1;
						ram_raddr = wr_ne_rd ? rd_q : ring_next(wr_idx_q);
						state_d   = S_CHECK;
					end else begin
						ram_we    = 1'b1;
						ram_waddr = wr_idx_q;
						ram_wdata = cmd.data;
					end
				end
			end
			S_CHECK: begin
				if (beyond_margin) begin
					ram_re    = 1'b1;
					ram_raddr = ring_next(start_pos);
					state_d   = S_SCAN;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SCAN: begin
				// Every byte passed is marked consumed, header or not.
				ram_we = 1'b1;
				if (hit) begin
					ram_re  = 1'b1;
					state_d = S_COPY;
				end else if (beyond_margin && (guard_inc < GW'(GUARD_LIMIT))) begin
					ram_re = 1'b1;
				end else begin
					state_d = S_DONE;
				end
			end
			S_COPY: begin
				ram_we = 1'b1;
				if (k_q != K_LAST) begin
					ram_re = 1'b1;
				end else if (!near_end && beyond_margin && (guard_q < GW'(GUARD_LIMIT))) begin
					ram_re  = 1'b1;
					state_d = S_SCAN;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wr_idx_q    <= '0;
			prev_wr_q   <= '0;
			rd_q        <= '0;
			cur_q       <= '0;
			stall_q     <= '0;
			overrun_q   <= '0;
			frame_q     <= '0;
			got_q       <= 1'b0;
			k_q         <= '0;
			guard_q     <= '0;
			valid_q     <= '0;
			rvalid_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			state_q <= state_d;
			if (ram_re) begin
				rvalid_q <= valid_q[ram_raddr];
				cur_q    <= ram_raddr;
			end else if (state_q == S_CHECK) begin
				cur_q <= start_pos;
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						if (cmd.poll) begin
							got_q <= 1'b0;
						end else begin
							wr_idx_q <= ring_next(wr_idx_q);
						end
					end
				end
				S_CHECK: begin
					guard_q <= '0;
					if (consumed) begin
						if (wr_ne_rd && (wr_idx_q != prev_wr_q)) begin
							stall_q <= '0;
						end else begin
							stall_q <= sat_inc(stall_q);
						end
					end else begin
						overrun_q <= sat_inc(overrun_q);
					end
				end
				S_SCAN: begin
					guard_q <= guard_inc;
					if (hit) begin
						got_q <= 1'b1;
						k_q   <= '0;
					end
				end
				S_COPY: begin
					frame_q[2'(k_q)] <= data_eff;
					k_q              <= k_q + 1'b1;
				end
				S_DONE: begin
					if (out_free) begin
						rd_q                     <= cur_q;
						prev_wr_q                <= wr_idx_q;
						out_data_q.frame_byte_0  <= frame_q[0];
						out_data_q.frame_byte_1  <= frame_q[1];
						out_data_q.frame_byte_2  <= frame_q[2];
						out_data_q.frame_byte_3  <= frame_q[3];
						out_data_q.new_frame     <= got_q;
						out_data_q.stall_count   <= stall_q;
						out_data_q.overrun_count <= overrun_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_q <= LAST_IDX) && (wr_idx_q <= LAST_IDX) && (cur_q <= LAST_IDX))
		else $error("ring index outside the ring");

	a_tally_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(stall_q <= TALLY_MAX) && (overrun_q <= TALLY_MAX))
		else $error("tally above saturation limit");

	a_copy_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_COPY |-> k_q <= K_LAST)
		else $error("frame copy ran past the frame length");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(out_data_q))
		else $error("pending result lost before it was taken");

endmodule

// File: test/ring_buffer_frame_extractor_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the ring buffer frame extractor: random framed traffic, live prediction.
module ring_buffer_frame_extractor_test;
	import rbfe_pkg::*;

	localparam int PHASES = 7;
	localparam int PHASE_ITEMS = 205;
	localparam int SETTLE_CYCLES = 100;
	localparam int SCAN_LIMIT = 4 * RING_DEPTH_DEF + 8;
	localparam logic [2:0] PHASE_HEADER_ID [PHASES] = '{3'd5, 3'd7, 3'd3, 3'd6, 3'd0, 3'd1, 3'd2};
	localparam logic [5:0] PHASE_BACKOFF [PHASES] = '{6'd0, 6'd63, 6'd20, 6'd1, 6'd62, 6'd31, 6'd10};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	in_item_t pending_items [$];
	out_item_t expected_reports [$];
	out_item_t want_report;
	int queued_total = 0;
	int fail_count = 0;
	bit calm = 1'b0;

	// Shadow copy of the block's state and registers
	logic [7:0] ring_model [RING_DEPTH_DEF] = '{default: 8'h00};
	logic [5:0] wr_model = '0;
	logic [5:0] prev_wr_model = '0;
	logic [5:0] rd_model = '0;
	int stall_model = 0;
	int overrun_model = 0;
	logic [7:0] frame_model [MAX_FRAME_BYTES] = '{default: 8'h00};
	logic [2:0] hdr_cfg = HEADER_ID_RESET;
	logic [5:0] backoff_cfg = BACKOFF_RESET;

	ring_buffer_frame_extractor DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Apply one accepted item to the shadow state; a poll yields the expected report.
	task automatic track_item(input in_item_t item);
		logic [5:0] wrt;
		logic [5:0] rd;
		int header;
		int guard;
		bit got;
		out_item_t report;
		if (item.op == OP_STORE) begin
			ring_model[wr_model] = item.rx_byte;
			wr_model = wr_model + 6'd1;
		end else begin
			wrt = wr_model;
			rd = rd_model;
			got = 1'b0;
			if (wrt != rd) begin
				if (ring_model[rd] == CONSUMED_MARK) begin
					if (wrt != prev_wr_model)
						stall_model = 0;
					else
						stall_model++;
				end else begin
					overrun_model++;
					rd = wrt - backoff_cfg;
				end
			end else if (ring_model[6'(wrt + 6'd1)] == CONSUMED_MARK) begin
				stall_model++;
			end else begin
				overrun_model++;
				rd = wrt - backoff_cfg;
			end
			if (stall_model > int'(TALLY_MAX))
				stall_model = int'(TALLY_MAX);
			if (overrun_model > int'(TALLY_MAX))
				overrun_model = int'(TALLY_MAX);

			header = int'(HEADER_BASE) + int'(hdr_cfg);
			guard = 0;
			while (6'(wrt - rd) > (backoff_cfg >> 1) && guard < SCAN_LIMIT) begin
				guard++;
				rd = rd + 6'd1;
				if (int'(ring_model[rd]) == header) begin
					ring_model[rd] = CONSUMED_MARK;
					for (int k = 0; k < FRAME_BYTES_DEF; k++) begin
						rd = rd + 6'd1;
						frame_model[k] = ring_model[rd];
						ring_model[rd] = CONSUMED_MARK;
					end
					got = 1'b1;
					// stop once less than half the ring is left unread
					if (6'(wrt - rd) < RING_DEPTH_DEF / 2)
						break;
				end else begin
					ring_model[rd] = CONSUMED_MARK;
				end
			end
			rd_model = rd;
			prev_wr_model = wrt;

			report.frame_byte_0 = frame_model[0];
			report.frame_byte_1 = frame_model[1];
			report.frame_byte_2 = frame_model[2];
			report.frame_byte_3 = frame_model[3];
			report.new_frame = got;
			report.stall_count = 16'(stall_model);
			report.overrun_count = 16'(overrun_model);
			expected_reports.push_back(report);
		end
	endtask

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Driver: present the next pending item, idling at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready)
				track_item(in_data);
			if (!in_valid || in_ready) begin
				if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 31)) begin
					in_valid <= 1'b1;
					in_data <= pending_items.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each accepted report with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_reports.size() == 0) begin
					$error("report with no poll pending: %p", out_data);
					fail_count++;
				end else begin
					want_report = expected_reports.pop_front();
					check_field("frame_byte_0", want_report.frame_byte_0, out_data.frame_byte_0);
					check_field("frame_byte_1", want_report.frame_byte_1, out_data.frame_byte_1);
					check_field("frame_byte_2", want_report.frame_byte_2, out_data.frame_byte_2);
					check_field("frame_byte_3", want_report.frame_byte_3, out_data.frame_byte_3);
					check_field("new_frame", want_report.new_frame, out_data.new_frame);
					check_field("stall_count", want_report.stall_count, out_data.stall_count);
					check_field("overrun_count", want_report.overrun_count,
						out_data.overrun_count);
				end
			end
			out_ready <= calm || ($urandom_range(0, 99) >= 31);
		end
	end

	task automatic push_store(input logic [7:0] value);
		pending_items.push_back('{op: OP_STORE, rx_byte: value});
		queued_total++;
	endtask

	task automatic push_poll();
		pending_items.push_back('{op: OP_POLL, rx_byte: 8'($urandom)});
		queued_total++;
	endtask

	// Mostly uniform bytes, with a bias toward header values and the consumed mark.
	function automatic logic [7:0] random_byte();
		if ($urandom_range(0, 99) < 20)
			return 8'($urandom_range(245, 255));
		return 8'($urandom_range(0, 255));
	endfunction

	// Mostly well-formed frames between polls; noise, cut frames and overrun bursts besides.
	task automatic queue_traffic(input int count, input logic [2:0] hdr);
		int stop_at;
		int pick;
		int len;
		logic [7:0] header;
		stop_at = queued_total + count;
		while (queued_total < stop_at) begin
			pick = $urandom_range(0, 99);
			if (hdr <= 3'd5)
				header = 8'(int'(HEADER_BASE) + int'(hdr));
			else
				header = 8'(int'(HEADER_BASE) + $urandom_range(0, 5));
			if (pick < 60) begin
				push_store(header);
				repeat (FRAME_BYTES_DEF) push_store(random_byte());
			end else if (pick < 78) begin
				push_poll();
			end else if (pick < 88) begin
				len = $urandom_range(1, 6);
				repeat (len) push_store(random_byte());
			end else if (pick < 95) begin
				len = $urandom_range(0, FRAME_BYTES_DEF - 1);
				push_store(header);
				repeat (len) push_store(random_byte());
			end else begin
				len = $urandom_range(40, 80);
				repeat (len) push_store(random_byte());
			end
		end
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (index == REG_HEADER_ID)
			hdr_cfg = value[2:0];
		else
			backoff_cfg = value[5:0];
	endtask

	// Wait until every item is taken and every report is in, then let stores settle.
	task automatic wait_drained();
		while (pending_items.size() != 0 || in_valid || expected_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// first poll sees the zeroed ring
		push_poll();
		push_store(8'd250);
		push_store(8'h00);
		push_store(8'hFF);
		push_store(8'h80);
		push_store(8'h01);
		push_store(8'hAA);
		push_poll();
		push_poll();
		push_store(8'd250);
		push_store(8'd250);
		push_store(8'h07);
		push_store(8'h08);
		push_store(8'h09);
		push_store(8'hFF);
		push_poll();
		// header with its frame cut short
		push_store(8'd250);
		push_poll();
		push_poll();
		queue_traffic(PHASE_ITEMS, HEADER_ID_RESET);
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			calm = (p == 3);
			write_register(REG_HEADER_ID, {5'($urandom), PHASE_HEADER_ID[p]});
			write_register(REG_RESYNC_BACKOFF, {2'($urandom), PHASE_BACKOFF[p]});
			queue_traffic(PHASE_ITEMS, PHASE_HEADER_ID[p]);
			wait_drained();
		end

		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
